// ===== rtl/tcce_pkg.sv =====
// Shared constants, codes and types of the text console character engine.
`default_nettype none

package tcce_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CELL_W   = 16;
   localparam int OFFSET_W = 11;

   localparam logic [COL_W-1:0]  COL_COUNT = COL_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_COUNT = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

   // Character codes
   localparam logic [7:0] CH_BLANK      = 8'h20;
   localparam logic [7:0] CH_LAST_PRINT = 8'h7E;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_BACKSPACE  = 8'h08;
   localparam logic [7:0] CH_RETURN     = 8'h0D;
   localparam logic [7:0] RESET_COLOR   = 8'h07;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_COLOR     = 2'd0;
   localparam logic [1:0] REG_TAB_WIDTH = 2'd1;
   localparam logic [1:0] REG_SCROLL    = 2'd2;

   localparam logic [7:0] RESET_TAB_WIDTH = 8'd8;

   typedef struct packed {
      logic [7:0]       color;
      logic [COL_W-1:0] tab_width;
      logic             scroll_en;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_PUT,
      OP_SPACE,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_READ,
      OP_MOD_INIT,
      OP_MOD_STEP,
      OP_TAB_INIT,
      OP_COPY,
      OP_BLANK,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_newline;
      logic is_tab;
      logic is_backspace;
      logic is_return;
      logic is_print;
      logic col_last;
      logic line_last;
      logic scroll_en;
      logic copy_last;
      logic idx_last;
      logic rem_ge_w;
      logic cnt_one;
      logic rsp_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_NEWLINE,
      ST_MOD,
      ST_TAB,
      ST_COPY,
      ST_BLANK,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/tcce_csr.sv =====
// Configuration register file with an APB-style write and read port.
`default_nettype none

module tcce_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tcce_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output tcce_pkg::cfg_type                   cfg
);
   import tcce_pkg::*;

   logic [7:0]       color_ff, color_in;
   logic [COL_W-1:0] tab_ff, tab_in;
   logic             scroll_ff, scroll_in;
   logic             wr_en;
   logic [1:0]       index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[3:2];

   always_comb begin
      color_in  = color_ff;
      tab_in    = tab_ff;
      scroll_in = scroll_ff;
      if (wr_en) begin
         unique case (index)
            REG_COLOR:     color_in  = pwdata[7:0];
            REG_TAB_WIDTH: tab_in    = pwdata[COL_W-1:0];
            REG_SCROLL:    scroll_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_COLOR:     prdata = {24'd0, color_ff};
         REG_TAB_WIDTH: prdata = {{(32-COL_W){1'b0}}, tab_ff};
         REG_SCROLL:    prdata = {31'd0, scroll_ff};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff  <= RESET_COLOR;
         tab_ff    <= RESET_TAB_WIDTH[COL_W-1:0];
         scroll_ff <= 1'b1;
      end else begin
         color_ff  <= color_in;
         tab_ff    <= tab_in;
         scroll_ff <= scroll_in;
      end
   end

   assign cfg.color     = color_ff;
   assign cfg.tab_width = tab_ff;
   assign cfg.scroll_en = scroll_ff;

endmodule

`default_nettype wire

// ===== rtl/tcce_ctrl.sv =====
// Controller state machine that sequences the screen datapath.
`default_nettype none

module tcce_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire tcce_pkg::dp_status_type status,
   output logic                         req_stall,
   output tcce_pkg::dp_cmd_type         cmd
);
   import tcce_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            if (status.is_read) begin
               cmd.op = OP_READ;
            end else if (status.is_newline) begin
               cmd.op = OP_NEWLINE;
               if (status.line_last && status.scroll_en) state_in = ST_COPY;
            end else if (status.is_tab) begin
               cmd.op   = OP_MOD_INIT;
               state_in = ST_MOD;
            end else if (status.is_backspace) begin
               cmd.op = OP_BACKSPACE;
            end else if (status.is_return) begin
               cmd.op = OP_RETURN;
            end else if (status.is_print) begin
               cmd.op = OP_PUT;
               if (status.col_last) state_in = ST_NEWLINE;
            end
         end
         ST_NEWLINE: begin
            cmd.op = OP_NEWLINE;
            if (status.line_last && status.scroll_en) state_in = ST_COPY;
            else                                      state_in = ST_FINISH;
         end
         ST_MOD: begin
            // Reduce the column modulo the tab width, one subtract a cycle
            if (status.rem_ge_w) begin
               cmd.op = OP_MOD_STEP;
            end else begin
               cmd.op   = OP_TAB_INIT;
               state_in = ST_TAB;
            end
         end
         ST_TAB: begin
            cmd.op = OP_SPACE;
            if (status.col_last)     state_in = ST_NEWLINE;
            else if (status.cnt_one) state_in = ST_FINISH;
         end
         ST_COPY: begin
            cmd.op = OP_COPY;
            if (status.copy_last) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.op = OP_BLANK;
            if (status.idx_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (status.rsp_free) begin
               cmd.op   = OP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/tcce_dp.sv =====
// Screen datapath: cell memory, cursor, tab and scroll counters, result register.
`default_nettype none

module tcce_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcce_pkg::dp_cmd_type          cmd,
   input  wire tcce_pkg::cfg_type             cfg,
   input  wire logic                          req_opcode,
   input  wire logic [7:0]                    req_char_code,
   input  wire logic [tcce_pkg::ROW_W-1:0]    req_read_row,
   input  wire logic [tcce_pkg::COL_W-1:0]    req_read_col,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic      [tcce_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic      [tcce_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic      [tcce_pkg::OFFSET_W-1:0] rsp_cursor_offset,
   output logic      [7:0]                    rsp_cell_char,
   output logic      [7:0]                    rsp_cell_color,
   output tcce_pkg::dp_status_type            status
);
   import tcce_pkg::*;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   logic              wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] wr_data_ff, wr_data_in;
   logic              wr_from_rd_ff, wr_from_rd_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [COL_W-1:0]  rem_ff, rem_in;
   logic [COL_W-1:0]  cnt_ff, cnt_in;

   logic              opcode_ff, opcode_in;
   logic [7:0]        char_ff, char_in;
   logic [ROW_W-1:0]  rrow_ff, rrow_in;
   logic [COL_W-1:0]  rcol_ff, rcol_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic [7:0]          rsp_color_ff, rsp_color_in;

   logic [COL_W-1:0]  w_eff;
   logic              in_range;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ROW_STEP + ADDR_W'(c);
   endfunction

   assign w_eff    = (cfg.tab_width == '0) ? COL_W'(1) : cfg.tab_width;
   assign in_range = (rrow_ff < ROW_COUNT) && (rcol_ff < COL_COUNT);

   always_comb begin
      col_in        = col_ff;
      line_in       = line_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      opcode_in     = opcode_ff;
      char_in       = char_ff;
      rrow_in       = rrow_ff;
      rcol_in       = rcol_ff;
      wr_en_in      = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      wr_from_rd_in = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff + ROW_STEP;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_color_in  = rsp_color_ff;

      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            opcode_in = req_opcode;
            char_in   = req_char_code;
            rrow_in   = req_read_row;
            rcol_in   = req_read_col;
         end
         OP_CLEAR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = idx_ff;
            wr_data_in = {RESET_COLOR, CH_BLANK};
            idx_in     = idx_ff + ADDR_W'(1);
         end
         OP_PUT: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cell_addr(line_ff, col_ff);
            wr_data_in = {cfg.color, char_ff};
            col_in     = col_ff + COL_W'(1);
         end
         OP_SPACE: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cell_addr(line_ff, col_ff);
            wr_data_in = {cfg.color, CH_BLANK};
            col_in     = col_ff + COL_W'(1);
            cnt_in     = cnt_ff - COL_W'(1);
         end
         OP_NEWLINE: begin
            col_in = '0;
            idx_in = '0;
            if (line_ff != LAST_ROW) line_in = line_ff + ROW_W'(1);
         end
         OP_RETURN: col_in = '0;
         OP_BACKSPACE: begin
            wr_data_in = {cfg.color, CH_BLANK};
            if (col_ff != '0) begin
               col_in     = col_ff - COL_W'(1);
               wr_en_in   = 1'b1;
               wr_addr_in = cell_addr(line_ff, col_ff - COL_W'(1));
            end else if (line_ff != '0) begin
               line_in    = line_ff - ROW_W'(1);
               col_in     = LAST_COL;
               wr_en_in   = 1'b1;
               wr_addr_in = cell_addr(line_ff - ROW_W'(1), LAST_COL);
            end
         end
         OP_READ: begin
            rd_en   = in_range;
            rd_addr = cell_addr(rrow_ff, rcol_ff);
         end
         OP_MOD_INIT: rem_in = col_ff;
         OP_MOD_STEP: rem_in = rem_ff - w_eff;
         OP_TAB_INIT: cnt_in = w_eff - rem_ff;
         OP_COPY: begin
            // Read the cell one row below; write it back here next cycle
            rd_en         = 1'b1;
            rd_addr       = idx_ff + ROW_STEP;
            wr_en_in      = 1'b1;
            wr_addr_in    = idx_ff;
            wr_from_rd_in = 1'b1;
            idx_in        = idx_ff + ADDR_W'(1);
         end
         OP_BLANK: begin
            wr_en_in   = 1'b1;
            wr_addr_in = idx_ff;
            wr_data_in = {cfg.color, CH_BLANK};
            idx_in     = idx_ff + ADDR_W'(1);
         end
         OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_col_in    = col_ff;
            rsp_row_in    = line_ff;
            rsp_offset_in = OFFSET_W'(cell_addr(line_ff, col_ff));
            if (opcode_ff && in_range) begin
               rsp_char_in  = rd_data_ff[7:0];
               rsp_color_in = rd_data_ff[15:8];
            end else begin
               rsp_char_in  = '0;
               rsp_color_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en_ff) mem[wr_addr_ff] <= wr_from_rd_ff ? rd_data_ff : wr_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         idx_ff       <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         idx_ff       <= idx_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      opcode_ff     <= opcode_in;
      char_ff       <= char_in;
      rrow_ff       <= rrow_in;
      rcol_ff       <= rcol_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      wr_from_rd_ff <= wr_from_rd_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign status.is_read      = opcode_ff;
   assign status.is_newline   = (char_ff == CH_NEWLINE);
   assign status.is_tab       = (char_ff == CH_TAB);
   assign status.is_backspace = (char_ff == CH_BACKSPACE);
   assign status.is_return    = (char_ff == CH_RETURN);
   assign status.is_print     = (char_ff >= CH_BLANK) && (char_ff <= CH_LAST_PRINT);
   assign status.col_last     = (col_ff == LAST_COL);
   assign status.line_last    = (line_ff == LAST_ROW);
   assign status.scroll_en    = cfg.scroll_en;
   assign status.copy_last    = (idx_ff == LAST_COPY);
   assign status.idx_last     = (idx_ff == LAST_CELL);
   assign status.rem_ge_w     = (rem_ff >= w_eff);
   assign status.cnt_one      = (cnt_ff == COL_W'(1));
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_offset = rsp_offset_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_color    = rsp_color_ff;

endmodule

`default_nettype wire

// ===== rtl/text_console_char_engine.sv =====
// Top level of the text console character engine.
//
// A 25 x 80 screen of character/attribute cells and a cursor. The req_
// channel carries one item per transfer: a put (opcode 0) of one byte, or
// a read (opcode 1) of the cell at req_read_row/req_read_col. Every item
// returns one rsp_ transfer with the cursor after the item; a read on the
// screen also returns the cell; a put or an off-screen read returns zeros.
// A put of an ordinary byte that does not wrap, a newline without scroll, a
// return, a backspace or a read passes through accept, decode and the
// result register. A tab first reduces the column modulo the width, one
// subtract a step, then writes one space per step. A scroll walks the cell
// memory through its single read and write port: it copies 1920 cells
// up a row and blanks 80. One item is in work at a time; the next is
// taken as soon as the previous result sits in the output register.
// Reset clears the cursor and result flag, then sweeps all 2000 cells to a
// blank with color 0x07, one cell a cycle, with req_stall held high. When
// the receiver stalls, the result holds in the output register and the
// block takes one more item, whose result waits until the register frees.
`default_nettype none

module text_console_char_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_opcode,
   input  wire logic [7:0]                     req_char_code,
   input  wire logic [tcce_pkg::ROW_W-1:0]     req_read_row,
   input  wire logic [tcce_pkg::COL_W-1:0]     req_read_col,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [tcce_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic      [tcce_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic      [tcce_pkg::OFFSET_W-1:0]  rsp_cursor_offset,
   output logic      [7:0]                     rsp_cell_char,
   output logic      [7:0]                     rsp_cell_color,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tcce_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);
   import tcce_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   tcce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tcce_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_col      (req_read_col),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_color    (rsp_cell_color),
      .status            (status)
   );

   // One item in work at a time: a transfer is followed by a stalled cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous item in work");

   // A new result appears only from the result command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.op == OP_RESP))
      else $error("result valid without result command");

   // The reported cursor lies on the screen and the offset matches it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_col < COL_COUNT) && (rsp_cursor_row < ROW_COUNT) &&
         (rsp_cursor_offset == OFFSET_W'(OFFSET_W'(rsp_cursor_row) * OFFSET_W'(COLUMNS)
                                         + OFFSET_W'(rsp_cursor_col))))
      else $error("cursor offset or position out of step");

   // A result for a put item carries no cell
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESP && !status.is_read) |=> (rsp_cell_char == '0) && (rsp_cell_color == '0))
      else $error("put result carries cell data");

endmodule

`default_nettype wire

// ===== sim/text_console_char_engine_test.sv =====
// Self-checking testbench for the text console character engine.
`timescale 1ns / 100ps

module text_console_char_engine_test;
   import tcce_pkg::*;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int CYCLE_LIMIT = 20_000_000;

   typedef struct packed {
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [OFFSET_W-1:0] offset;
      logic [7:0]          ch;
      logic [7:0]          attr;
   } cursor_report_type;

   // Screen and cursor tracker with the queue of reports still owed.
   class console_scoreboard;
      logic [15:0]       cells [CELLS];
      int                cur_col;
      int                cur_row;
      logic [7:0]        attr;
      logic [COL_W-1:0]  tab_w;
      logic              scroll_on;
      cursor_report_type pending [$];
      int                faults;

      function new();
         foreach (cells[i]) cells[i] = {RESET_COLOR, CH_BLANK};
         cur_col   = 0;
         cur_row   = 0;
         attr      = RESET_COLOR;
         tab_w     = COL_W'(RESET_TAB_WIDTH);
         scroll_on = 1'b1;
         faults    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_COLOR: attr = value[7:0];
            REG_TAB_WIDTH: tab_w = value[COL_W-1:0];
            REG_SCROLL: scroll_on = value[0];
            default: ;
         endcase
      endfunction

      function void scroll_screen();
         for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_BLANK};
      endfunction

      function void new_line();
         cur_col = 0;
         cur_row++;
         if (cur_row >= ROWS) begin
            if (scroll_on) scroll_screen();
            cur_row = ROWS - 1;
         end
      endfunction

      // Return 1 when the write wrapped the line.
      function bit put_printable(logic [7:0] ch);
         cells[cur_row * COLUMNS + cur_col] = {attr, ch};
         cur_col++;
         if (cur_col >= COLUMNS) begin
            new_line();
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void tab_forward();
         int w;
         int stop;
         w = (tab_w == 0) ? 1 : int'(tab_w);
         stop = (cur_col / w + 1) * w;
         while (cur_col < stop && cur_col < COLUMNS) begin
            if (put_printable(CH_BLANK)) break;
         end
      endfunction

      function void back_space();
         if (cur_col > 0) begin
            cur_col--;
            cells[cur_row * COLUMNS + cur_col] = {attr, CH_BLANK};
         end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLUMNS - 1;
            cells[cur_row * COLUMNS + cur_col] = {attr, CH_BLANK};
         end
      endfunction

      function void note_item(logic op, logic [7:0] ch, int rrow, int rcol);
         cursor_report_type r;
         r.ch   = 8'h00;
         r.attr = 8'h00;
         if (op == REQ_PUT) begin
            if (ch == CH_NEWLINE) new_line();
            else if (ch == CH_TAB) tab_forward();
            else if (ch == CH_BACKSPACE) back_space();
            else if (ch == CH_RETURN) cur_col = 0;
            else if (ch >= CH_BLANK && ch <= CH_LAST_PRINT) void'(put_printable(ch));
         end else if (rrow < ROWS && rcol < COLUMNS) begin
            r.ch   = cells[rrow * COLUMNS + rcol][7:0];
            r.attr = cells[rrow * COLUMNS + rcol][15:8];
         end
         r.col    = COL_W'(cur_col);
         r.row    = ROW_W'(cur_row);
         r.offset = OFFSET_W'(cur_row * COLUMNS + cur_col);
         pending.push_back(r);
      endfunction

      function void check_result(cursor_report_type got);
         cursor_report_type want;
         if (pending.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: col %0d row %0d offset %0d char %02h color %02h",
                        got.col, got.row, got.offset, got.ch, got.attr);
            return;
         end
         want = pending.pop_front();
         if (want.col != got.col || want.row != got.row || want.offset != got.offset ||
             want.ch != got.ch || want.attr != got.attr) begin
            faults++;
            if (faults <= 10) begin
               $write("mismatch: expected col %0d row %0d offset %0d char %02h color %02h,",
                      want.col, want.row, want.offset, want.ch, want.attr);
               $display(" got col %0d row %0d offset %0d char %02h color %02h",
                        got.col, got.row, got.offset, got.ch, got.attr);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = 1'b0;
   logic [7:0]            req_char_code = 8'h00;
   logic [ROW_W-1:0]      req_read_row = '0;
   logic [COL_W-1:0]      req_read_col = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COL_W-1:0]      rsp_cursor_col;
   logic [ROW_W-1:0]      rsp_cursor_row;
   logic [OFFSET_W-1:0]   rsp_cursor_offset;
   logic [7:0]            rsp_cell_char;
   logic [7:0]            rsp_cell_color;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   console_scoreboard sb;
   bit gaps_on   = 1'b1;
   bit stalls_on = 1'b1;
   int hold_left = 0;
   int cycle_count = 0;

   text_console_char_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_char_code(req_char_code), .req_read_row(req_read_row),
      .req_read_col(req_read_col),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row), .rsp_cursor_offset(rsp_cursor_offset),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_color(rsp_cell_color),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: check each transfer, then hold stall for a random count.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result('{rsp_cursor_col, rsp_cursor_row, rsp_cursor_offset,
                              rsp_cell_char, rsp_cell_color});
            hold_left = stalls_on ? $urandom_range(0, 5) : 0;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] ch, input int rr, input int rc);
      int gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_char_code <= ch;
      req_read_row  <= ROW_W'(rr);
      req_read_col  <= COL_W'(rc);
      do @(posedge clock); while (req_stall);
      sb.note_item(op, ch, rr, rc);
   endtask

   // Drop valid and hold until every owed result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   initial begin
      int handled;
      int pick;
      int run;
      logic [7:0] ch;
      logic [7:0] set_color;
      int set_tab;
      logic set_scroll;

      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Edge cases under the reset settings.
      send_item(REQ_PUT, CH_BACKSPACE, 0, 0);
      send_item(REQ_READ, 8'hFF, 0, 0);
      send_item(REQ_READ, 8'h00, ROWS - 1, COLUMNS - 1);
      send_item(REQ_READ, 8'h5A, 31, 127);
      send_item(REQ_READ, 8'h00, ROWS, 5);
      send_item(REQ_READ, 8'h00, 3, COLUMNS);
      send_item(REQ_PUT, 8'h41, 31, 127);
      send_item(REQ_PUT, CH_BLANK, 0, 0);
      send_item(REQ_PUT, CH_LAST_PRINT, 0, 0);
      send_item(REQ_PUT, 8'h7F, 0, 0);
      send_item(REQ_PUT, 8'h00, 0, 0);
      send_item(REQ_PUT, 8'hFF, 0, 0);
      send_item(REQ_PUT, 8'h80, 0, 0);
      send_item(REQ_PUT, 8'h1F, 0, 0);
      send_item(REQ_PUT, CH_TAB, 0, 0);
      send_item(REQ_PUT, CH_BACKSPACE, 0, 0);
      send_item(REQ_PUT, CH_RETURN, 0, 0);
      send_item(REQ_READ, 8'h00, 0, 0);
      send_item(REQ_PUT, CH_NEWLINE, 0, 0);
      send_item(REQ_PUT, CH_BACKSPACE, 0, 0);
      send_item(REQ_READ, 8'h00, 0, COLUMNS - 1);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin set_color = 8'h00; set_tab = 1;   set_scroll = 1'b0; end
            1: begin set_color = 8'hFF; set_tab = 80;  set_scroll = 1'b1; end
            2: begin set_color = 8'h1E; set_tab = 0;   set_scroll = 1'b0; end
            3: begin set_color = 8'hA5; set_tab = 127; set_scroll = 1'b1; end
            4: begin set_color = 8'h07; set_tab = 8;   set_scroll = 1'b1; end
            default: begin
               set_color  = 8'($urandom_range(0, 255));
               set_tab    = $urandom_range(1, 80);
               set_scroll = 1'($urandom_range(0, 1));
            end
         endcase
         // One stretch runs with neither side idling.
         gaps_on   = (phase != 4);
         stalls_on = (phase != 4);
         write_csr(REG_COLOR, 32'(set_color));
         write_csr(REG_TAB_WIDTH, 32'(set_tab));
         write_csr(REG_SCROLL, 32'(set_scroll));

         handled = 0;
         while (handled < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick == 0) begin
               // Line of text, long enough to wrap now and then.
               wait_idle();
               run = $urandom_range(10, 85);
               repeat (run)
                  send_item(REQ_PUT, 8'($urandom_range(int'(CH_BLANK), int'(CH_LAST_PRINT))),
                            $urandom_range(0, 31), $urandom_range(0, 127));
               handled += run;
            end else if (pick < 13) begin
               send_item(REQ_READ, 8'($urandom_range(0, 255)), sb.cur_row,
                         $urandom_range(0, COLUMNS - 1));
               handled++;
            end else if (pick < 23) begin
               send_item(REQ_READ, 8'($urandom_range(0, 255)), $urandom_range(0, ROWS - 1),
                         $urandom_range(0, COLUMNS - 1));
               handled++;
            end else if (pick < 28) begin
               send_item(REQ_READ, 8'($urandom_range(0, 255)), $urandom_range(0, 31),
                         $urandom_range(0, 127));
               handled++;
            end else begin
               if (pick < 34) ch = CH_NEWLINE;
               else if (pick < 39) ch = CH_TAB;
               else if (pick < 45) ch = CH_BACKSPACE;
               else if (pick < 49) ch = CH_RETURN;
               else if (pick < 55) ch = 8'($urandom_range(0, 255));
               else ch = 8'($urandom_range(int'(CH_BLANK), int'(CH_LAST_PRINT)));
               send_item(REQ_PUT, ch, $urandom_range(0, 31), $urandom_range(0, 127));
               if (ch == CH_NEWLINE || ch == CH_TAB || ch == CH_BACKSPACE ||
                   ch == CH_RETURN || (ch >= CH_BLANK && ch <= CH_LAST_PRINT))
                  handled++;
            end
         end
         wait_idle();
      end

      if (sb.faults == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tcce_pkg.sv
rtl/tcce_csr.sv
rtl/tcce_ctrl.sv
rtl/tcce_dp.sv
rtl/text_console_char_engine.sv
sim/text_console_char_engine_test.sv
